>>> rtl/bdt_pkg.sv
package bdt_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int SCAN_WIDTH  = 16;
  localparam int NUM_LIGHTS  = 10;

  localparam int SCAN_W      = 16;
  localparam int LED_W       = 16;
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 16;
  localparam int NIB_W       = 4;
  localparam int MAP_W       = 40;
  localparam int CFG_DATA_W  = 40;
  localparam int CFG_INDEX_W = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [MAP_W-1:0] BTN_MAP_RESET  = 40'h47E89ABDCF;
  localparam logic [MAP_W-1:0] LED_MAP_RESET  = 40'h9876543210;

  localparam logic [SCAN_W-1:0] SCAN_MASK = {SCAN_W{1'b1}} >> (SCAN_W - SCAN_WIDTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_ACTIVE_LOW = 2'd1,
    CFG_BTN_MAP    = 2'd2,
    CFG_LED_MAP    = 2'd3
  } cfg_index_t;

  // Entries past the end of the map register read as zero.
  function automatic logic [NIB_W-1:0] map_entry(input logic [MAP_W-1:0] map,
                                                 input int unsigned idx);
    logic [NIB_W-1:0] entry;
    entry = '0;
    if ((idx + 1) * NIB_W <= MAP_W) begin
      entry = map[idx*NIB_W +: NIB_W];
    end
    return entry;
  endfunction

endpackage

>>> rtl/button_debounce_toggle_top.sv
// Debounced button scanner that toggles LEDs on presses. Each input beat is one
// poll (scan word plus millisecond timestamp) and produces exactly one output
// beat on the cycle after acceptance; a new poll is accepted every cycle while
// the output register is empty or being drained. The per-poll path is the
// button bit selection followed by one 32-bit wrapping subtract and compare
// against the debounce time. The first poll after reset only primes the state
// and reports no edges. Configuration writes take effect on the next poll.
module button_debounce_toggle_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bdt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdt_pkg::SCAN_W-1:0]        scan_word,
  input  logic [bdt_pkg::TIME_W-1:0]        now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bdt_pkg::LED_W-1:0]         led_word,
  output logic                              led_update,
  output logic [bdt_pkg::NUM_BUTTONS-1:0]   stable_pressed,
  output logic [bdt_pkg::NUM_BUTTONS-1:0]   rising_edges
);
  import bdt_pkg::*;

  logic [DEB_W-1:0]       debounce_time;
  logic                   active_low;
  logic [MAP_W-1:0]       button_bit_map;
  logic [MAP_W-1:0]       light_map;

  logic [NUM_BUTTONS-1:0] raw_mask;
  logic [NUM_BUTTONS-1:0] stable_mask;
  logic [TIME_W-1:0]      change_time;
  logic [LED_W-1:0]       led_bits;
  logic                   primed;

  logic [NUM_BUTTONS-1:0] raw_in;
  logic [TIME_W-1:0]      change_time_next;
  logic [TIME_W-1:0]      elapsed;
  logic                   accept_stable;
  logic [NUM_BUTTONS-1:0] stable_mask_next;
  logic [NUM_BUTTONS-1:0] rising_next;
  logic [LED_W-1:0]       toggle;
  logic                   in_beat;

  bdt_press_map u_press_map (
    .scan_word      (scan_word),
    .active_low     (active_low),
    .button_bit_map (button_bit_map),
    .raw            (raw_in)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  assign change_time_next = (!primed || (raw_in != raw_mask)) ? now_ms : change_time;
  assign elapsed          = now_ms - change_time_next;
  assign accept_stable    = primed && (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_time})
                            && (stable_mask != raw_in);
  assign stable_mask_next = (!primed || accept_stable) ? raw_in : stable_mask;
  assign rising_next      = accept_stable ? (raw_in & ~stable_mask) : '0;

  always_comb begin
    toggle = '0;
    for (int j = 0; j < LED_W; j++) begin
      for (int i = 0; i < NUM_BUTTONS && i < NUM_LIGHTS; i++) begin
        toggle[j] = toggle[j] ^ (rising_next[i] && (map_entry(light_map, i) == NIB_W'(j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time  <= DEBOUNCE_RESET;
      active_low     <= 1'b1;
      button_bit_map <= BTN_MAP_RESET;
      light_map      <= LED_MAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_time  <= cfg_data[DEB_W-1:0];
        CFG_ACTIVE_LOW: active_low     <= cfg_data[0];
        CFG_BTN_MAP:    button_bit_map <= cfg_data[MAP_W-1:0];
        CFG_LED_MAP:    light_map      <= cfg_data[MAP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mask    <= '0;
      stable_mask <= '0;
      change_time <= '0;
      led_bits    <= '0;
      primed      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_beat) begin
        raw_mask    <= raw_in;
        stable_mask <= stable_mask_next;
        change_time <= change_time_next;
        led_bits    <= led_bits ^ toggle;
        primed      <= 1'b1;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      rising_edges <= rising_next;
      led_update   <= (rising_next != '0);
    end
  end

  assign led_word       = led_bits;
  assign stable_pressed = stable_mask;

`ifndef ASSERT_OFF
  a_update_matches_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (led_update == (rising_edges != '0)))
    else $error("led_update disagrees with rising_edges");

  a_edges_in_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rising_edges & ~stable_pressed) == '0))
    else $error("rising edge reported for a button not in the stable mask");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> out_valid)
    else $error("accepted poll produced no result");

  a_first_poll_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !primed) |=> (!led_update && (rising_edges == '0)))
    else $error("priming poll reported edges");

  a_leds_change_on_update: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> ((led_word == $past(led_bits)) || led_update))
    else $error("LED word changed without an accepted edge");
`endif

endmodule

>>> rtl/bdt_press_map.sv
module bdt_press_map (
  input  logic [bdt_pkg::SCAN_W-1:0]      scan_word,
  input  logic                            active_low,
  input  logic [bdt_pkg::MAP_W-1:0]       button_bit_map,
  output logic [bdt_pkg::NUM_BUTTONS-1:0] raw
);
  import bdt_pkg::*;

  logic [SCAN_W-1:0] scan_masked;

  assign scan_masked = scan_word & SCAN_MASK;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      raw[i] = scan_masked[map_entry(button_bit_map, i)] ^ active_low;
    end
  end

endmodule

>>> test/tb_button_debounce_toggle_top.sv
module tb_button_debounce_toggle_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdt_pkg::*;

  typedef struct packed {
    logic [LED_W-1:0]       leds;
    logic                   update;
    logic [NUM_BUTTONS-1:0] stable;
    logic [NUM_BUTTONS-1:0] rising;
  } light_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SCAN_W-1:0]      scan_word;
  logic [TIME_W-1:0]      now_ms;
  logic                   out_valid;
  logic                   out_ready;
  logic [LED_W-1:0]       led_word;
  logic                   led_update;
  logic [NUM_BUTTONS-1:0] stable_pressed;
  logic [NUM_BUTTONS-1:0] rising_edges;

  button_debounce_toggle_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .scan_word(scan_word),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_word(led_word),
    .led_update(led_update),
    .stable_pressed(stable_pressed),
    .rising_edges(rising_edges)
  );

  // Shadow copy of the configuration and of the debounce state.
  logic [DEB_W-1:0]       debounce_q;
  logic                   active_low_q;
  logic [MAP_W-1:0]       btn_map_q;
  logic [MAP_W-1:0]       led_map_q;
  logic [NUM_BUTTONS-1:0] raw_q;
  logic [NUM_BUTTONS-1:0] stable_q;
  logic [TIME_W-1:0]      change_q;
  logic [LED_W-1:0]       leds_q;
  logic                   primed_q;

  light_result_t pending_lights[$];
  light_result_t front_beat;

  logic        gaps_on;
  logic [31:0] ms_now;
  logic [15:0] target_scan;
  int          bounce_left;
  int          err_count;
  int          polls_sent;
  int          presses_seen;
  int          writes_done;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [NUM_BUTTONS-1:0] pressed_from_scan(input logic [SCAN_W-1:0] scan);
    logic [NUM_BUTTONS-1:0] mask;
    logic [NIB_W-1:0]       pos;
    mask = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      pos = btn_map_q[NIB_W*i +: NIB_W];
      mask[i] = ((pos < SCAN_WIDTH) ? scan[pos] : 1'b0) ^ active_low_q;
    end
    return mask;
  endfunction

  task automatic predict_poll(input logic [SCAN_W-1:0] scan, input logic [TIME_W-1:0] t);
    logic [NUM_BUTTONS-1:0] raw;
    logic [NUM_BUTTONS-1:0] rising;
    logic [TIME_W-1:0]      elapsed;
    light_result_t          res;
    raw = pressed_from_scan(scan);
    rising = '0;
    if (!primed_q) begin
      raw_q = raw;
      stable_q = raw;
      change_q = t;
      primed_q = 1'b1;
    end else begin
      if (raw != raw_q) begin
        raw_q = raw;
        change_q = t;
      end
      elapsed = t - change_q;
      if (elapsed >= {16'b0, debounce_q} && stable_q != raw_q) begin
        rising = raw_q & ~stable_q;
        stable_q = raw_q;
        for (int i = 0; i < NUM_BUTTONS && i < NUM_LIGHTS; i++) begin
          if (rising[i]) begin
            leds_q[led_map_q[NIB_W*i +: NIB_W]] ^= 1'b1;
          end
        end
      end
    end
    res.leds = leds_q;
    res.update = |rising;
    res.stable = stable_q;
    res.rising = rising;
    pending_lights.push_back(res);
  endtask

  // Entered at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_poll(input logic [SCAN_W-1:0] scan, input logic [TIME_W-1:0] t);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    scan_word <= scan;
    now_ms <= t;
    do @(posedge clk); while (!in_ready);
    predict_poll(scan, t);
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_lights.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: begin
        debounce_q = value[DEB_W-1:0];
      end
      CFG_ACTIVE_LOW: begin
        active_low_q = value[0];
      end
      CFG_BTN_MAP: begin
        btn_map_q = value[MAP_W-1:0];
      end
      CFG_LED_MAP: begin
        led_map_q = value[MAP_W-1:0];
      end
      default: begin
      end
    endcase
    writes_done++;
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= 6) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_lights.size() == 0) begin
        $error("output beat with no expected result");
        err_count++;
      end else begin
        front_beat = pending_lights.pop_front();
        check_field("led_word", 16'(front_beat.leds), 16'(led_word));
        check_field("led_update", 16'(front_beat.update), 16'(led_update));
        check_field("stable_pressed", 16'(front_beat.stable), 16'(stable_pressed));
        check_field("rising_edges", 16'(front_beat.rising), 16'(rising_edges));
        if (front_beat.rising != '0) begin
          presses_seen++;
        end
      end
    end
  end

  // With the default button map, button 0 reads scan bit 15 and button 7 reads bit 14.
  task automatic test_priming_and_wrap();
    send_poll(16'h0000, 32'hFFFF_FFF0);
    send_poll(16'h0000, 32'hFFFF_FFF8);
    send_poll(16'hFFFF, 32'hFFFF_FFFA);
    send_poll(16'hFFFF, 32'h0000_0017);
    send_poll(16'hFFFF, 32'h0000_0018);
    send_poll(16'h7FFF, 32'h0000_0020);
    send_poll(16'h7FFF, 32'h0000_003D);
    send_poll(16'h7FFF, 32'h0000_003E);
    send_poll(16'hFFFF, 32'h0000_0040);
    send_poll(16'hFFFF, 32'h0000_0060);
    send_poll(16'h0000, 32'h0000_0061);
    send_poll(16'h0000, 32'h0000_007F);
    send_poll(16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_debounce_extremes();
    drain_results();
    write_reg(CFG_DEBOUNCE, 40'd0);
    send_poll(16'hFFFF, 32'd100);
    send_poll(16'hBFFF, 32'd100);
    drain_results();
    write_reg(CFG_DEBOUNCE, 40'hFFFF);
    send_poll(16'hFFFF, 32'd200);
    send_poll(16'hFFFF, 32'd200 + 32'd65534);
    send_poll(16'hFFFF, 32'd200 + 32'd65535);
  endtask

  task automatic test_polarity_and_maps();
    drain_results();
    write_reg(CFG_DEBOUNCE, 40'd0);
    write_reg(CFG_ACTIVE_LOW, 40'd0);
    write_reg(CFG_BTN_MAP, 40'h00_0000_0000);
    write_reg(CFG_LED_MAP, 40'hFF_FFFF_FFFF);
    send_poll(16'h0001, 32'd1000);
    send_poll(16'h0000, 32'd1001);
    drain_results();
    write_reg(CFG_BTN_MAP, 40'hFF_FFFF_FFFF);
    write_reg(CFG_LED_MAP, 40'h00_0000_00F0);
    send_poll(16'h8000, 32'd1002);
    send_poll(16'h0000, 32'd1003);
  endtask

  task automatic test_random_polls(input int count);
    logic [SCAN_W-1:0] scan;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) begin
        scan = 16'($urandom);
        if ($urandom_range(1) == 0) begin
          ms_now = $urandom;
        end
      end else begin
        if ($urandom_range(99) < 10) begin
          if ($urandom_range(3) == 0) begin
            target_scan = 16'($urandom);
          end else begin
            target_scan = target_scan ^ (16'h1 << $urandom_range(15));
          end
          bounce_left = $urandom_range(4);
        end
        scan = target_scan;
        if (bounce_left > 0) begin
          scan = scan ^ (16'($urandom) & 16'($urandom));
          bounce_left--;
        end
        ms_now = ms_now + $urandom_range(12);
      end
      send_poll(scan, ms_now);
    end
  endtask

  task automatic test_random_settings();
    drain_results();
    write_reg(CFG_ACTIVE_LOW, 40'd1);
    write_reg(CFG_BTN_MAP, BTN_MAP_RESET);
    write_reg(CFG_LED_MAP, LED_MAP_RESET);
    write_reg(CFG_DEBOUNCE, 40'($urandom_range(30, 1)));
    test_random_polls(350);

    drain_results();
    gaps_on = 1'b0;
    write_reg(CFG_ACTIVE_LOW, 40'd0);
    write_reg(CFG_BTN_MAP, 40'({$urandom, $urandom}));
    write_reg(CFG_LED_MAP, 40'({$urandom, $urandom}));
    write_reg(CFG_DEBOUNCE, 40'($urandom_range(20)));
    test_random_polls(350);

    drain_results();
    gaps_on = 1'b1;
    write_reg(CFG_ACTIVE_LOW, 40'($urandom_range(1)));
    write_reg(CFG_BTN_MAP, 40'({$urandom, $urandom}));
    write_reg(CFG_LED_MAP, 40'({$urandom, $urandom}));
    write_reg(CFG_DEBOUNCE, 40'($urandom_range(60)));
    test_random_polls(350);

    drain_results();
    write_reg(CFG_ACTIVE_LOW, 40'd1);
    write_reg(CFG_LED_MAP, 40'({$urandom, $urandom}));
    write_reg(CFG_DEBOUNCE, 40'($urandom_range(8)));
    test_random_polls(350);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    scan_word = '0;
    now_ms = '0;
    out_ready = 1'b0;
    gaps_on = 1'b1;
    debounce_q = DEBOUNCE_RESET;
    active_low_q = 1'b1;
    btn_map_q = BTN_MAP_RESET;
    led_map_q = LED_MAP_RESET;
    raw_q = '0;
    stable_q = '0;
    change_q = '0;
    leds_q = '0;
    primed_q = 1'b0;
    ms_now = $urandom;
    target_scan = 16'($urandom);
    bounce_left = 0;
    err_count = 0;
    polls_sent = 0;
    presses_seen = 0;
    writes_done = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_priming_and_wrap();
    test_debounce_extremes();
    test_polarity_and_maps();
    test_random_settings();
    drain_results();

    $display("Sent %0d polls, %0d of them produced accepted presses, after %0d register writes.",
             polls_sent, presses_seen, writes_done);
    $display("Settings covered both polarities, fixed and random maps, debounce 0 to 65535.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: not all expected beats arrived.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
